[src/cptl_pkg.sv]
// ----------------------------------------------------------------------------
// Carrier phase tracking loop package
// Widths, register indexes, command op codes, command and status types
// and the arctangent table in turns at 2^32 per turn.
// ----------------------------------------------------------------------------
package cptl_pkg;

  localparam int SampleWidth  = 16;
  localparam int CordicStages = 16;
  localparam int FracBits     = 8;
  localparam int TableLen     = 24;
  localparam int NumStages    = (CordicStages < TableLen) ? CordicStages : TableLen;
  localparam int StageW       = $clog2(NumStages + 1);
  // Working width of the CORDIC x and y values.
  localparam int WorkW        = SampleWidth + FracBits + 3;
  localparam int GainW        = 32;
  localparam int PhaseW       = 32;
  localparam int ErrW         = 16;
  localparam int CfgIdxW      = 1;

  localparam logic [CfgIdxW-1:0] RegPropGain = 1'd0;
  localparam logic [CfgIdxW-1:0] RegIntGain  = 1'd1;

  localparam logic [GainW-1:0] PropGainReset = 32'd108244879;
  localparam logic [GainW-1:0] IntGainReset  = 32'd190172;
  localparam logic [25:0]      InvGainQ24    = 26'd10188014;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_ROTATE,
    OP_SCALE,
    OP_VEC_INIT,
    OP_VECTOR,
    OP_FILTER,
    OP_UPDATE
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [StageW-1:0] stage;
  } cmd_t;

  typedef struct packed {
    logic zero_vec;
  } stat_t;

  function automatic logic [31:0] atan_turns(input logic [4:0] k);
    logic [31:0] v;
    case (k)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

[src/cptl_if.sv]
// ----------------------------------------------------------------------------
// Carrier phase tracking loop channels
// Valid/ready channels for input samples and loop results.
// ----------------------------------------------------------------------------
interface cptl_in_if import cptl_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] sample_i;
  logic signed [SampleWidth-1:0] sample_q;
  logic                          slice_end;
  modport source (output valid, sample_i, sample_q, slice_end, input ready);
  modport sink (input valid, sample_i, sample_q, slice_end, output ready);
endinterface

interface cptl_out_if import cptl_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] derotated_i;
  logic signed [SampleWidth-1:0] derotated_q;
  logic signed [31:0]            proportional_term;
  logic signed [31:0]            integrator_value;
  logic                          slice_end_out;
  modport source (output valid, derotated_i, derotated_q, proportional_term,
                  integrator_value, slice_end_out, input ready);
  modport sink (input valid, derotated_i, derotated_q, proportional_term,
                integrator_value, slice_end_out, output ready);
endinterface

[src/cptl_ctrl.sv]
// ----------------------------------------------------------------------------
// Carrier phase tracking loop controller
// Sequences load, rotation, scaling, vectoring and loop filter steps.
// ----------------------------------------------------------------------------
module cptl_ctrl import cptl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StRotate = 3'd1;
  localparam logic [2:0] StScale  = 3'd2;
  localparam logic [2:0] StVInit  = 3'd3;
  localparam logic [2:0] StVector = 3'd4;
  localparam logic [2:0] StFilter = 3'd5;
  localparam logic [2:0] StUpdate = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [StageW-1:0] stage_q, stage_d;
  logic              out_valid_q, out_valid_d;
  logic              last_stage;

  assign last_stage = (stage_q == StageW'(NumStages - 1));
  // The result register may still be full while a new sample is worked on;
  // only the final write waits for it.
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    stage_d     = stage_q;
    out_valid_d = out_valid_q;
    cmd_o.op    = OP_NONE;
    cmd_o.stage = stage_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          stage_d  = '0;
          state_d  = StRotate;
        end
      end
      StRotate: begin
        cmd_o.op = OP_ROTATE;
        stage_d  = stage_q + 1'b1;
        if (last_stage) begin
          state_d = StScale;
        end
      end
      StScale: begin
        cmd_o.op = OP_SCALE;
        state_d  = StVInit;
      end
      StVInit: begin
        cmd_o.op = OP_VEC_INIT;
        stage_d  = '0;
        state_d  = stat_i.zero_vec ? StFilter : StVector;
      end
      StVector: begin
        cmd_o.op = OP_VECTOR;
        stage_d  = stage_q + 1'b1;
        if (last_stage) begin
          state_d = StFilter;
        end
      end
      StFilter: begin
        cmd_o.op = OP_FILTER;
        state_d  = StUpdate;
      end
      StUpdate: begin
        if (!out_valid_d) begin
          cmd_o.op    = OP_UPDATE;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      stage_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stage_q     <= stage_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_update_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_UPDATE) |=> out_valid_q)
    else $error("result not shown after update");
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == StRotate) && (stage_q == '0))
    else $error("accepted item did not start rotation");
  a_stage_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRotate || state_q == StVector) |-> stage_q < StageW'(NumStages))
    else $error("stage counter out of range");

endmodule

[src/cptl_dpath.sv]
// ----------------------------------------------------------------------------
// Carrier phase tracking loop datapath
// Shared CORDIC unit, gain scaling, loop filter, NCO and result register.
// ----------------------------------------------------------------------------
module cptl_dpath import cptl_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cmd_t                          cmd_i,
  output stat_t                         stat_o,
  input  logic                          cfg_we_i,
  input  logic [CfgIdxW-1:0]            cfg_idx_i,
  input  logic [GainW-1:0]              cfg_data_i,
  input  logic signed [SampleWidth-1:0] in_i_i,
  input  logic signed [SampleWidth-1:0] in_q_i,
  input  logic                          in_end_i,
  output logic signed [SampleWidth-1:0] out_i_o,
  output logic signed [SampleWidth-1:0] out_q_o,
  output logic signed [31:0]            out_p_o,
  output logic signed [31:0]            out_f_o,
  output logic                          out_end_o
);

  localparam int ProdW = WorkW + 27;
  localparam int RndSh = 24 + FracBits;
  localparam logic signed [SampleWidth-1:0] SMax = {1'b0, {(SampleWidth-1){1'b1}}};
  localparam logic signed [SampleWidth-1:0] SMin = {1'b1, {(SampleWidth-1){1'b0}}};

  logic [GainW-1:0]              pgain_q, igain_q;
  logic [PhaseW-1:0]             nco_q;
  logic signed [31:0]            integ_q;
  logic signed [WorkW-1:0]       x_q, y_q, x_d, y_d;
  logic signed [32:0]            z_q, z_d;
  logic signed [SampleWidth-1:0] di_q, dq_q;
  logic                          end_q;
  logic signed [ErrW-1:0]        err_q, err_d;
  logic signed [31:0]            p_q, f_q;
  logic signed [SampleWidth-1:0] oi_q, oq_q;
  logic signed [31:0]            op_q, of_q;
  logic                          oend_q;

  logic [31:0]             ang;
  logic [1:0]              quad;
  logic signed [WorkW-1:0] xl, yl, xs, ys, ax, ay;
  logic [31:0]             atn;
  logic signed [ProdW-1:0] prx, pry;
  logic signed [SampleWidth-1:0] sx, sy;
  logic signed [49:0]      pp, pi, rp, ri;
  logic signed [33:0]      fsum;
  logic signed [31:0]      p_sat, f_sat;
  logic [31:0]             za_round;

  function automatic logic signed [SampleWidth-1:0] scale_sat(
      input logic signed [ProdW-1:0] v);
    logic [ProdW-1:0]        mag;
    logic [ProdW-1:0]        r;
    logic signed [ProdW-1:0] s;
    mag = v[ProdW-1] ? ProdW'(-v) : ProdW'(v);
    r   = (mag + (ProdW'(1) << (RndSh - 1))) >> RndSh;
    s   = v[ProdW-1] ? -$signed(r) : $signed(r);
    if (s > ProdW'(SMax)) begin
      return SMax;
    end else if (s < ProdW'(SMin)) begin
      return SMin;
    end
    return s[SampleWidth-1:0];
  endfunction

  function automatic logic signed [49:0] round16(input logic signed [49:0] v);
    logic [49:0] mag;
    logic [49:0] r;
    mag = v[49] ? 50'(-v) : 50'(v);
    r   = (mag + 50'd32768) >> 16;
    return v[49] ? -$signed(r) : $signed(r);
  endfunction

  assign ang  = (32'd0 - nco_q) + 32'h2000_0000;
  assign quad = ang[31:30];
  assign atn  = atan_turns(5'(cmd_i.stage));
  assign xs   = x_q >>> cmd_i.stage;
  assign ys   = y_q >>> cmd_i.stage;
  assign prx  = ProdW'(x_q) * $signed({1'b0, InvGainQ24});
  assign pry  = ProdW'(y_q) * $signed({1'b0, InvGainQ24});
  assign sx   = scale_sat(prx);
  assign sy   = scale_sat(pry);
  assign stat_o.zero_vec = (di_q == '0) && (dq_q == '0);
  assign ax   = WorkW'(di_q) <<< FracBits;
  assign ay   = WorkW'(dq_q) <<< FracBits;
  assign pp   = 50'(err_q) * $signed({1'b0, pgain_q});
  assign pi   = 50'(err_q) * $signed({1'b0, igain_q});
  assign rp   = round16(pp);
  assign ri   = round16(pi);
  assign p_sat = (rp > 50'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
                 (rp < -50'sh8000_0000) ? 32'sh8000_0000 : rp[31:0];
  assign fsum = 34'(integ_q) + 34'(ri[33:0]);
  assign f_sat = (fsum > 34'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
                 (fsum < -34'sh8000_0000) ? 32'sh8000_0000 : fsum[31:0];

  always_comb begin
    xl = WorkW'(in_i_i) <<< FracBits;
    yl = WorkW'(in_q_i) <<< FracBits;
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    err_d = err_q;
    za_round = '0;
    case (cmd_i.op)
      OP_LOAD: begin
        z_d = 33'($signed({1'b0, ang[29:0]})) - 33'sh2000_0000;
        case (quad)
          2'd1: begin x_d = -yl; y_d = xl; end
          2'd2: begin x_d = -xl; y_d = -yl; end
          2'd3: begin x_d = yl; y_d = -xl; end
          default: begin x_d = xl; y_d = yl; end
        endcase
      end
      OP_ROTATE: begin
        if (!z_q[32]) begin
          x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - 33'(atn);
        end else begin
          x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + 33'(atn);
        end
      end
      OP_VEC_INIT: begin
        err_d = '0;
        if (ax[WorkW-1]) begin
          x_d = -ax; y_d = -ay; z_d = 33'h0_8000_0000;
        end else begin
          x_d = ax; y_d = ay; z_d = '0;
        end
      end
      OP_VECTOR: begin
        if (!y_q[WorkW-1]) begin
          x_d = x_q + ys; y_d = y_q - xs; z_d = {1'b0, z_q[31:0] + atn};
        end else begin
          x_d = x_q - ys; y_d = y_q + xs; z_d = {1'b0, z_q[31:0] - atn};
        end
        if (cmd_i.stage == StageW'(NumStages - 1)) begin
          za_round = z_d[31:0] + 32'h8000;
          err_d    = $signed(za_round[31:16]);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pgain_q <= PropGainReset;
      igain_q <= IntGainReset;
      nco_q   <= '0;
      integ_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegPropGain: pgain_q <= cfg_data_i;
          RegIntGain:  igain_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.op == OP_UPDATE) begin
        integ_q <= f_q;
        nco_q   <= nco_q + p_q + f_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    err_q <= err_d;
    if (cmd_i.op == OP_LOAD) begin
      end_q <= in_end_i;
    end
    if (cmd_i.op == OP_SCALE) begin
      di_q <= sx;
      dq_q <= sy;
    end
    if (cmd_i.op == OP_FILTER) begin
      p_q <= p_sat;
      f_q <= f_sat;
    end
    if (cmd_i.op == OP_UPDATE) begin
      oi_q   <= di_q;
      oq_q   <= dq_q;
      op_q   <= p_q;
      of_q   <= f_q;
      oend_q <= end_q;
    end
  end

  assign out_i_o   = oi_q;
  assign out_q_o   = oq_q;
  assign out_p_o   = op_q;
  assign out_f_o   = of_q;
  assign out_end_o = oend_q;

endmodule

[src/costas_phase_tracking_loop_top.sv]
// ----------------------------------------------------------------------------
// Costas phase tracking loop top level
// Second-order carrier loop with CORDIC derotation and arctangent detector.
// ----------------------------------------------------------------------------
// A sample is accepted and loaded into the CORDIC in the same cycle. Its result
// then takes 16 rotation steps and 16 vectoring steps of a single shared CORDIC
// unit, a scaling step, a setup step, a loop filter step and one NCO update.
// A zero vector skips the vectoring steps. The NCO feedback runs through both
// CORDIC passes, so the block takes no new sample before the update is done;
// the update itself waits while the result register is still full. The next
// sample is taken right after the update, while the previous result may still
// wait in the output register.
module costas_phase_tracking_loop_top import cptl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [GainW-1:0]   cfg_data_i,
  cptl_in_if.sink            in_ch,
  cptl_out_if.source         out_ch
);

  cmd_t  cmd;
  stat_t stat;

  cptl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cptl_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i_i     (in_ch.sample_i),
    .in_q_i     (in_ch.sample_q),
    .in_end_i   (in_ch.slice_end),
    .out_i_o    (out_ch.derotated_i),
    .out_q_o    (out_ch.derotated_q),
    .out_p_o    (out_ch.proportional_term),
    .out_f_o    (out_ch.integrator_value),
    .out_end_o  (out_ch.slice_end_out)
  );

endmodule
